[hdl/pdc_pkg.sv]
// pdc_pkg: shared types and constants for the packet deframer with checksum
// used by the config channel interface and every module under packet_deframer_checksum_core
// no dependencies

package pdc_pkg;

    // config register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_START_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_CODE = 2'd2;

    // config reset values
    localparam logic [7:0] RST_START_CODE  = 8'd2;
    localparam logic [7:0] RST_END_CODE    = 8'd3;
    localparam logic [7:0] RST_ESCAPE_CODE = 8'd16;

    // result event codes
    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_PAYLOAD = 2'd1;
    localparam logic [1:0] EV_GOOD    = 2'd2;
    localparam logic [1:0] EV_BAD     = 2'd3;

    // framing codes currently in force
    typedef struct packed {
        logic [7:0] start_code;
        logic [7:0] end_code;
        logic [7:0] escape_code;
    } codes_t;

    // one result item
    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] payload_byte;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
    } result_t;

endpackage

[hdl/pdc_in_if.sv]
// pdc_in_if: valid/ready channel carrying one received byte per item
// no dependencies

interface pdc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

[hdl/pdc_out_if.sv]
// pdc_out_if: valid/ready channel carrying one decoder result per item
// no dependencies

interface pdc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] payload_byte;
    logic [7:0] byte_index;
    logic [7:0] frame_length;

    modport source (output valid, output event_res, output payload_byte,
                    output byte_index, output frame_length, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input byte_index, input frame_length, output ready);
endinterface

[hdl/pdc_cfg_if.sv]
// pdc_cfg_if: valid/ready register write channel (index and data)
// depends on pdc_pkg for the index width

interface pdc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pdc_pkg::CFG_IDX_W-1:0]  index;
    logic [7:0]                     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/pdc_cfg_regs.sv]
// pdc_cfg_regs: holds the start, end and escape codes written over the config channel
// depends on pdc_pkg and pdc_cfg_if

module pdc_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    pdc_cfg_if.sink           cfg,
    output pdc_pkg::codes_t   codes
);

    pdc_pkg::codes_t codes_reg;
    pdc_pkg::codes_t codes_next;

    // writes are always taken
    assign cfg.ready = 1'b1;

    // register file write decode, unknown indexes are dropped
    always_comb
    begin
        codes_next = codes_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                pdc_pkg::REG_START_CODE:  codes_next.start_code  = cfg.data;
                pdc_pkg::REG_END_CODE:    codes_next.end_code    = cfg.data;
                pdc_pkg::REG_ESCAPE_CODE: codes_next.escape_code = cfg.data;
                default:                  codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.start_code  <= pdc_pkg::RST_START_CODE;
            codes_reg.end_code    <= pdc_pkg::RST_END_CODE;
            codes_reg.escape_code <= pdc_pkg::RST_ESCAPE_CODE;
        end
        else
        begin
            codes_reg <= codes_next;
        end
    end

    assign codes = codes_reg;

endmodule

[hdl/pdc_frame_fsm.sv]
// pdc_frame_fsm: frame hunt, unstuffing and checksum state with the per-item step logic
// depends on pdc_pkg

module pdc_frame_fsm #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         in_byte,
    input  pdc_pkg::codes_t    codes,
    output pdc_pkg::result_t   res
);

    localparam logic [7:0] MaxPayload = 8'(MAX_PAYLOAD);

    // phase codes
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_HUNT = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;
    localparam logic [1:0] PH_ESC  = 2'd3;

    localparam logic [1:0] NEED_FULL = 2'd2;
    localparam logic [1:0] NEED_ONE  = 2'd1;

    logic [1:0] phase_reg;
    logic [1:0] phase_next;
    logic [1:0] need_reg;
    logic [1:0] need_next;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic [7:0] cnt_reg;
    logic [7:0] cnt_next;

    logic [1:0] need_cur;
    logic [7:0] sum_base;
    logic [7:0] cnt_base;
    logic       do_body;
    logic       do_lit;

    // one item: hunt, body byte or escaped literal
    always_comb
    begin
        res        = '0;
        phase_next = phase_reg;
        need_next  = need_reg;
        sum_base   = sum_reg;
        cnt_base   = cnt_reg;
        do_body    = 1'b0;
        do_lit     = 1'b0;
        need_cur   = (phase_reg == PH_IDLE) ? NEED_FULL : need_reg;

        if ((phase_reg == PH_IDLE) || (phase_reg == PH_HUNT))
        begin
            if (need_cur != 2'd0)
            begin
                phase_next = PH_HUNT;
                need_next  = (in_byte == codes.start_code) ? (need_cur - 2'd1) : NEED_FULL;
            end
            else
            begin
                // both start codes seen, this byte opens the body
                sum_base = '0;
                cnt_base = '0;
                do_body  = 1'b1;
            end
        end
        else if (phase_reg == PH_BODY)
        begin
            do_body = 1'b1;
        end
        else
        begin
            do_lit = 1'b1;
        end

        sum_next = sum_base;
        cnt_next = cnt_base;

        // body byte: end wins over start, start wins over escape
        if (do_body)
        begin
            if (in_byte == codes.end_code)
            begin
                phase_next = PH_IDLE;
                if (sum_base != 8'd0)
                begin
                    res.event_res = pdc_pkg::EV_BAD;
                end
                else if (cnt_base != 8'd0)
                begin
                    res.event_res    = pdc_pkg::EV_GOOD;
                    res.frame_length = cnt_base;
                end
            end
            else if (in_byte == codes.start_code)
            begin
                phase_next = PH_HUNT;
                need_next  = NEED_ONE;
            end
            else if (in_byte == codes.escape_code)
            begin
                phase_next = PH_ESC;
            end
            else
            begin
                do_lit = 1'b1;
            end
        end

        // literal byte: always summed, reported while there is room
        if (do_lit)
        begin
            phase_next = PH_BODY;
            sum_next   = sum_base + in_byte;
            if (cnt_base < MaxPayload)
            begin
                res.event_res    = pdc_pkg::EV_PAYLOAD;
                res.payload_byte = in_byte;
                res.byte_index   = cnt_base;
                cnt_next         = cnt_base + 8'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            need_reg  <= NEED_FULL;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            need_reg  <= need_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
        end
    end

    // stored count never passes the payload limit
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MaxPayload)
        else $error("stored count above payload limit");

    // hunting never needs more than two start codes
    a_need_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HUNT) |-> (need_reg != 2'd3))
        else $error("start code count out of range");

    // a reported payload byte leaves the stored count one past its index
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        (step && (res.event_res == pdc_pkg::EV_PAYLOAD))
        |=> (cnt_reg == ($past(res.byte_index) + 8'd1)))
        else $error("payload byte did not advance stored count");

    // a good frame always carries a nonzero length
    a_good_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res.event_res == pdc_pkg::EV_GOOD) |-> (res.frame_length != 8'd0))
        else $error("good frame with zero length");

endmodule

[hdl/packet_deframer_checksum_core.sv]
// packet_deframer_checksum_core: byte-stuffed frame decoder with 8-bit checksum
// path: byte accept to result valid goes through the input and result registers
// throughput: one byte per cycle unless result_ch stalls; frame state moves on step
// reset: rst_n asynchronous active low; clears both pipeline valids, the frame state
// and loads the default codes (start 2, end 3, escape 16); no clearing pass
// depends on pdc_pkg, pdc_in_if, pdc_out_if, pdc_cfg_if, pdc_cfg_regs, pdc_frame_fsm

module packet_deframer_checksum_core #(
    parameter int unsigned MAX_PAYLOAD = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    pdc_in_if.sink     byte_ch,
    pdc_out_if.source  result_ch,
    pdc_cfg_if.sink    cfg
);

    pdc_pkg::codes_t  codes;
    pdc_pkg::result_t step_res;

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    pdc_pkg::result_t  out_res_reg;

    logic out_free;
    logic advance;
    logic in_take;

    // config registers
    pdc_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .codes (codes)
    );

    // frame state and step logic
    pdc_frame_fsm #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_frame_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .in_byte (in_byte_reg),
        .codes   (codes),
        .res     (step_res)
    );

    // pipeline handshake
    assign out_free      = !out_valid_reg || result_ch.ready;
    assign advance       = in_valid_reg && out_free;
    assign byte_ch.ready = !in_valid_reg || out_free;
    assign in_take       = byte_ch.valid && byte_ch.ready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= byte_ch.in_byte;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    // result channel
    assign result_ch.valid        = out_valid_reg;
    assign result_ch.event_res    = out_res_reg.event_res;
    assign result_ch.payload_byte = out_res_reg.payload_byte;
    assign result_ch.byte_index   = out_res_reg.byte_index;
    assign result_ch.frame_length = out_res_reg.frame_length;

endmodule

[tb/testbench.sv]
// testbench for packet_deframer_checksum_core: directed byte table, then random framed traffic
// checks each result item against the table or an in-bench frame decoder under several code settings
// depends on pdc_pkg, pdc_in_if, pdc_out_if, pdc_cfg_if and the core itself
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned MAX_PAYLOAD = 64;
    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned ITEMS_PER_SETTING = 280;

    // index with no register behind it, writes are dropped
    localparam logic [pdc_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    // decoder phases of the bench model
    typedef enum logic [1:0] {
        FR_IDLE,
        FR_HUNT,
        FR_BODY,
        FR_ESCAPED
    } frame_phase_t;

    // one row of the directed byte table
    typedef struct {
        logic [7:0]       in_byte;
        bit               typed;
        pdc_pkg::result_t res;
    } byte_row_t;

    logic clk = 1'b0;
    logic rst_n;

    pdc_in_if  byte_if ();
    pdc_out_if result_if ();
    pdc_cfg_if cfg_if ();

    packet_deframer_checksum_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_if),
        .result_ch (result_if),
        .cfg       (cfg_if)
    );

    // bench copy of the decoder state and codes
    pdc_pkg::codes_t cur_codes;
    frame_phase_t    dec_phase;
    logic [1:0]      starts_left;
    logic [7:0]      body_sum;
    logic [7:0]      stored_cnt;

    pdc_pkg::result_t expected_results[$];
    byte_row_t        byte_table[$];
    int               fail_count = 0;
    int               bytes_sent = 0;
    int               cycle_count = 0;
    bit               steady_run = 1'b0;

    always #1 clk = ~clk;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("CHECKS FAILED");
        $finish;
    end

    // gap length: none during a steady run, else mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run) return 0;
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // decode one accepted byte, update bench state, return the result item
    function automatic pdc_pkg::result_t decode_byte(input logic [7:0] b);
        pdc_pkg::result_t res;
        bit               literal;
        res = '0;
        res.event_res = pdc_pkg::EV_NONE;
        literal = 1'b0;
        if (dec_phase == FR_IDLE)
        begin
            starts_left = 2'd2;
            dec_phase = FR_HUNT;
        end
        if (dec_phase == FR_HUNT && starts_left != 2'd0)
        begin
            if (b == cur_codes.start_code)
                starts_left = starts_left - 2'd1;
            else
                starts_left = 2'd2;
        end
        else
        begin
            // byte after the second start code is a body byte right away
            if (dec_phase == FR_HUNT)
            begin
                body_sum = 8'd0;
                stored_cnt = 8'd0;
                dec_phase = FR_BODY;
            end
            if (dec_phase == FR_ESCAPED)
                literal = 1'b1;
            else if (b == cur_codes.end_code)
            begin
                dec_phase = FR_IDLE;
                if (body_sum != 8'd0)
                    res.event_res = pdc_pkg::EV_BAD;
                else if (stored_cnt != 8'd0)
                begin
                    res.event_res = pdc_pkg::EV_GOOD;
                    res.frame_length = stored_cnt;
                end
            end
            else if (b == cur_codes.start_code)
            begin
                dec_phase = FR_HUNT;
                starts_left = 2'd1;
            end
            else if (b == cur_codes.escape_code)
                dec_phase = FR_ESCAPED;
            else
                literal = 1'b1;
            // literal byte: sum always, report only below the payload cap
            if (literal)
            begin
                if (stored_cnt < MAX_PAYLOAD)
                begin
                    res.event_res = pdc_pkg::EV_PAYLOAD;
                    res.payload_byte = b;
                    res.byte_index = stored_cnt;
                    stored_cnt = stored_cnt + 8'd1;
                end
                body_sum = body_sum + b;
                dec_phase = FR_BODY;
            end
        end
        return res;
    endfunction

    // send one byte item; typed rows carry their own expected result
    task automatic send_byte(input logic [7:0] b, input bit typed,
                             input pdc_pkg::result_t typed_res);
        int               gap;
        pdc_pkg::result_t predicted;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.in_byte <= b;
        do @(posedge clk); while (!byte_if.ready);
        predicted = decode_byte(b);
        expected_results.push_back(typed ? typed_res : predicted);
        bytes_sent++;
    endtask

    // body byte with escape stuffing where it matches a code
    task automatic send_body_byte(input logic [7:0] b);
        if (b == cur_codes.end_code || b == cur_codes.start_code
            || b == cur_codes.escape_code)
            send_byte(cur_codes.escape_code, 1'b0, '0);
        send_byte(b, 1'b0, '0);
    endtask

    // hold off the sender until every result item is back
    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
    endtask

    task automatic write_reg(input logic [pdc_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data <= data;
        do @(posedge clk); while (!cfg_if.ready);
        case (idx)
            pdc_pkg::REG_START_CODE:  cur_codes.start_code = data;
            pdc_pkg::REG_END_CODE:    cur_codes.end_code = data;
            pdc_pkg::REG_ESCAPE_CODE: cur_codes.escape_code = data;
            default: ;
        endcase
    endtask

    // new code setting, only with the block idle
    task automatic set_codes(input logic [7:0] s, input logic [7:0] e, input logic [7:0] x,
                             input bit spare);
        wait_drained();
        write_reg(pdc_pkg::REG_START_CODE, s);
        write_reg(pdc_pkg::REG_END_CODE, e);
        write_reg(pdc_pkg::REG_ESCAPE_CODE, x);
        if (spare)
            write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
        cfg_if.valid <= 1'b0;
    endtask

    // frame with stuffed body and checksum, optionally broken
    task automatic send_frame(input int body_len, input bit good_sum, input bit broken);
        logic [7:0] sum;
        logic [7:0] b;
        int         cut;
        int         i;
        sum = 8'd0;
        cut = (broken && body_len > 0) ? int'($urandom_range(0, body_len - 1)) : -1;
        send_byte(cur_codes.start_code, 1'b0, '0);
        send_byte(cur_codes.start_code, 1'b0, '0);
        for (i = 0; i < body_len; i++)
        begin
            // raw byte without stuffing breaks the frame
            if (i == cut)
                send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            send_body_byte(b);
        end
        b = good_sum ? 8'd0 - sum : 8'd0 - sum + 8'($urandom_range(1, 255));
        send_body_byte(b);
        if (!(broken && $urandom_range(0, 1)))
            send_byte(cur_codes.end_code, 1'b0, '0);
    endtask

    // mostly short frames, a few past the payload cap
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 12);
        if (r < 95) return $urandom_range(13, 40);
        return $urandom_range(MAX_PAYLOAD - 4, MAX_PAYLOAD + 16);
    endfunction

    // random traffic under the current codes
    task automatic run_random(input int count);
        int target;
        int r;
        int n;
        target = bytes_sent + count;
        while (bytes_sent < target)
        begin
            if ($urandom_range(0, 99) < 5)
                steady_run = ~steady_run;
            if ($urandom_range(0, 99) < 3)
                wait_drained();
            r = $urandom_range(0, 99);
            if (r < 70)
                send_frame(pick_len(), $urandom_range(0, 9) != 0, 1'b0);
            else if (r < 85)
                send_frame(pick_len(), 1'($urandom_range(0, 1)), 1'b1);
            else
            begin
                n = $urandom_range(1, 8);
                repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
        end
    endtask

    task automatic add_row(input logic [7:0] b, input bit typed, input logic [1:0] ev,
                           input logic [7:0] pb, input logic [7:0] idx, input logic [7:0] len);
        byte_row_t row;
        row.in_byte = b;
        row.typed = typed;
        row.res.event_res = ev;
        row.res.payload_byte = pb;
        row.res.byte_index = idx;
        row.res.frame_length = len;
        byte_table.push_back(row);
    endtask

    // result ready: busy stretches with random stalls
    initial
    begin
        int g;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            result_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            g = pick_gap();
            if (g > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin : check_results
        pdc_pkg::result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item: event_res %0d", result_if.event_res);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_if.event_res !== want.event_res)
                begin
                    $error("event_res: expected %0d, got %0d", want.event_res,
                           result_if.event_res);
                    fail_count++;
                end
                if (result_if.payload_byte !== want.payload_byte)
                begin
                    $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                           result_if.payload_byte);
                    fail_count++;
                end
                if (result_if.byte_index !== want.byte_index)
                begin
                    $error("byte_index: expected %0d, got %0d", want.byte_index,
                           result_if.byte_index);
                    fail_count++;
                end
                if (result_if.frame_length !== want.frame_length)
                begin
                    $error("frame_length: expected %0d, got %0d", want.frame_length,
                           result_if.frame_length);
                    fail_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin
        int i;
        rst_n <= 1'b0;
        byte_if.valid <= 1'b0;
        byte_if.in_byte <= 8'd0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= pdc_pkg::REG_START_CODE;
        cfg_if.data <= 8'd0;
        cur_codes.start_code = pdc_pkg::RST_START_CODE;
        cur_codes.end_code = pdc_pkg::RST_END_CODE;
        cur_codes.escape_code = pdc_pkg::RST_ESCAPE_CODE;
        dec_phase = FR_IDLE;
        starts_left = 2'd2;
        body_sum = 8'd0;
        stored_cnt = 8'd0;

        // default codes: start 02, end 03, escape 10
        add_row(8'h00, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'hFF, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h02, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h02, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h41, 1'b1, pdc_pkg::EV_PAYLOAD, 8'h41, 8'd0, 8'd0);
        // escaped start, escape and end codes are literal
        add_row(8'h10, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h02, 1'b1, pdc_pkg::EV_PAYLOAD, 8'h02, 8'd1, 8'd0);
        add_row(8'h10, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h10, 1'b1, pdc_pkg::EV_PAYLOAD, 8'h10, 8'd2, 8'd0);
        add_row(8'h10, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h03, 1'b1, pdc_pkg::EV_PAYLOAD, 8'h03, 8'd3, 8'd0);
        // checksum brings the sum to zero
        add_row(8'hAA, 1'b1, pdc_pkg::EV_PAYLOAD, 8'hAA, 8'd4, 8'd0);
        add_row(8'h03, 1'b1, pdc_pkg::EV_GOOD, 8'h00, 8'd0, 8'd5);
        // empty good frame reports nothing
        add_row(8'h02, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h02, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h03, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        // bad checksum
        add_row(8'h02, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h02, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'hFF, 1'b1, pdc_pkg::EV_PAYLOAD, 8'hFF, 8'd0, 8'd0);
        add_row(8'h03, 1'b1, pdc_pkg::EV_BAD, 8'h00, 8'd0, 8'd0);
        // start code inside the body restarts the hunt
        add_row(8'h02, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h02, 1'b1, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h00, 1'b1, pdc_pkg::EV_PAYLOAD, 8'h00, 8'd0, 8'd0);
        add_row(8'h02, 1'b0, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h02, 1'b0, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h5A, 1'b0, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);
        add_row(8'h03, 1'b0, pdc_pkg::EV_NONE, 8'h00, 8'd0, 8'd0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < byte_table.size(); i++)
            send_byte(byte_table[i].in_byte, byte_table[i].typed, byte_table[i].res);

        // random traffic over several code settings
        run_random(ITEMS_PER_SETTING);
        set_codes(8'h00, 8'hFF, 8'h80, 1'b0);
        run_random(ITEMS_PER_SETTING);
        // escape equals end: end wins
        set_codes(8'hFF, 8'h00, 8'h00, 1'b0);
        run_random(ITEMS_PER_SETTING);
        // start equals end: end wins
        set_codes(8'h7E, 8'h7E, 8'h7D, 1'b0);
        run_random(ITEMS_PER_SETTING);
        // start equals escape: start wins
        set_codes(8'h55, 8'hAA, 8'h55, 1'b0);
        run_random(ITEMS_PER_SETTING);
        set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'b1);
        run_random(ITEMS_PER_SETTING);
        set_codes(pdc_pkg::RST_START_CODE, pdc_pkg::RST_END_CODE,
                  pdc_pkg::RST_ESCAPE_CODE, 1'b0);
        run_random(ITEMS_PER_SETTING);

        // wind down
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
hdl/pdc_pkg.sv
hdl/pdc_in_if.sv
hdl/pdc_out_if.sv
hdl/pdc_cfg_if.sv
hdl/pdc_cfg_regs.sv
hdl/pdc_frame_fsm.sv
hdl/packet_deframer_checksum_core.sv
tb/testbench.sv
